// ===== rtl/tcspq_pkg.sv =====
`default_nettype none

package tcspq_pkg;

    // Queue sizing and identifier width.
    localparam int QUEUE_DEPTH = 64;
    localparam int ID_BITS     = 16;

    // Derived widths: ring pointers, occupancy counts and the padded data bus.
    localparam int PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_BITS = ((ID_BITS + 7) / 8) * 8;

    // Request kinds carried in the input tuser.
    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_SERVE = 1'b1
    } t_op;

    // Result codes carried in the output tuser.
    typedef enum logic [1:0] {
        ST_ADDED  = 2'd0,
        ST_SERVED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // Control that follows an item while its store read is in flight.
    typedef struct packed {
        t_status status;
        logic    from_urgent;
    } t_req_ctl;

endpackage

`default_nettype wire

// ===== rtl/tcspq_ram.sv =====
`default_nettype none

module tcspq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; the read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/two_class_strict_priority_queue.sv =====
`default_nettype none

// Two-class strict-priority queue of item identifiers.
// Input channel (s side): tdata carries the identifier, tuser[0] the request kind
// (add or serve) and tuser[1] the class on an add. Output channel (m side): one
// item per request, tdata the served identifier (zero unless served), tuser[1:0]
// the status and tuser[2] the urgent flag of the served item.
// An add goes to the tail of the queue that its class selects, or is rejected
// with the full status. A serve pops the urgent head first, then the normal head,
// otherwise it returns the empty status.
// Each result passes the synchronous store read and then the output register.
// Throughput: one request per cycle unless the receiver stalls, set by the single
// write and read port of each store; pointers and counts are updated in the
// accepting cycle. When the receiver stalls, the output register and the read
// stage hold and ready falls once both are occupied; no item is lost or repeated.
// Reset clears pointers, counts and valid flags, so both queues start empty at
// once; the stores themselves are not cleared and need no clearing pass.
module two_class_strict_priority_queue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // [ID_BITS-1:0] item_id, zero padding above
    input  wire logic [tcspq_pkg::DATA_BITS-1:0] i_s_tdata,
    // [0] operation, [1] urgent
    input  wire logic [1:0]                    i_s_tuser,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [ID_BITS-1:0] served_id, zero padding above
    output logic      [tcspq_pkg::DATA_BITS-1:0] o_m_tdata,
    // [1:0] status, [2] served_urgent
    output logic      [2:0]                    o_m_tuser
);

    import tcspq_pkg::*;

    function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
        ptr_next = (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Ring pointers and occupancy of both queues.
    logic [PTR_BITS-1:0] r_u_head, r_u_tail, r_n_head, r_n_tail;
    logic [PTR_BITS-1:0] n_u_head, n_u_tail, n_n_head, n_n_tail;
    logic [CNT_BITS-1:0] r_u_count, r_n_count, n_u_count, n_n_count;

    // Read stage and output register.
    logic     r_p_valid;
    t_req_ctl r_p_ctl, n_p_ctl;
    logic     r_o_valid;
    logic [ID_BITS-1:0] r_o_id;
    t_req_ctl r_o_ctl;

    logic s_accept, p_move;
    logic is_serve, is_urgent;
    logic u_full, n_full, u_empty, n_empty;
    logic u_we, n_we, u_re, n_re;
    logic [ID_BITS-1:0] in_id, u_rdata, n_rdata, p_id;

    assign in_id     = i_s_tdata[ID_BITS-1:0];
    assign is_serve  = (t_op'(i_s_tuser[0]) == OP_SERVE);
    assign is_urgent = i_s_tuser[1];

    assign u_full  = (r_u_count == CNT_BITS'(QUEUE_DEPTH));
    assign n_full  = (r_n_count == CNT_BITS'(QUEUE_DEPTH));
    assign u_empty = (r_u_count == '0);
    assign n_empty = (r_n_count == '0);

    // The read stage moves on when the output register is free or being drained.
    assign p_move     = r_p_valid && (!r_o_valid || i_m_tready);
    assign o_s_tready = !r_p_valid || p_move;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Decide the request, drive the store ports and update the pointers.
    always_comb begin
        n_u_head  = r_u_head;
        n_u_tail  = r_u_tail;
        n_n_head  = r_n_head;
        n_n_tail  = r_n_tail;
        n_u_count = r_u_count;
        n_n_count = r_n_count;
        u_we = 1'b0;
        n_we = 1'b0;
        u_re = 1'b0;
        n_re = 1'b0;
        n_p_ctl.status      = ST_EMPTY;
        n_p_ctl.from_urgent = 1'b0;
        if (s_accept) begin
            if (!is_serve) begin
                if (is_urgent) begin
                    if (u_full) begin
                        n_p_ctl.status = ST_FULL;
                    end else begin
                        n_p_ctl.status = ST_ADDED;
                        u_we      = 1'b1;
                        n_u_tail  = ptr_next(r_u_tail);
                        n_u_count = r_u_count + 1'b1;
                    end
                end else begin
                    if (n_full) begin
                        n_p_ctl.status = ST_FULL;
                    end else begin
                        n_p_ctl.status = ST_ADDED;
                        n_we      = 1'b1;
                        n_n_tail  = ptr_next(r_n_tail);
                        n_n_count = r_n_count + 1'b1;
                    end
                end
            end else if (!u_empty) begin
                n_p_ctl.status      = ST_SERVED;
                n_p_ctl.from_urgent = 1'b1;
                u_re      = 1'b1;
                n_u_head  = ptr_next(r_u_head);
                n_u_count = r_u_count - 1'b1;
            end else if (!n_empty) begin
                n_p_ctl.status = ST_SERVED;
                n_re      = 1'b1;
                n_n_head  = ptr_next(r_n_head);
                n_n_count = r_n_count - 1'b1;
            end else begin
                n_p_ctl.status = ST_EMPTY;
            end
        end
    end

    tcspq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_BITS)) u_urgent_store (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (r_u_tail),
        .i_wdata (in_id),
        .i_re    (u_re),
        .i_raddr (r_u_head),
        .o_rdata (u_rdata)
    );

    tcspq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_BITS)) u_normal_store (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r_n_tail),
        .i_wdata (in_id),
        .i_re    (n_re),
        .i_raddr (r_n_head),
        .o_rdata (n_rdata)
    );

    // Pointer and count registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_head  <= '0;
            r_u_tail  <= '0;
            r_n_head  <= '0;
            r_n_tail  <= '0;
            r_u_count <= '0;
            r_n_count <= '0;
        end else begin
            r_u_head  <= n_u_head;
            r_u_tail  <= n_u_tail;
            r_n_head  <= n_n_head;
            r_n_tail  <= n_n_tail;
            r_u_count <= n_u_count;
            r_n_count <= n_n_count;
        end
    end

    // The served identifier comes from the store that was read; zero otherwise.
    assign p_id = (r_p_ctl.status != ST_SERVED) ? '0 :
                  (r_p_ctl.from_urgent ? u_rdata : n_rdata);

    // Read stage valid flag and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_p_valid <= 1'b1;
            end else if (p_move) begin
                r_p_valid <= 1'b0;
            end
            if (p_move) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_p_ctl <= n_p_ctl;
        end
        if (p_move) begin
            r_o_id  <= p_id;
            r_o_ctl <= r_p_ctl;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = DATA_BITS'(r_o_id);
    assign o_m_tuser  = {r_o_ctl.from_urgent, r_o_ctl.status};

    // Occupancy never exceeds the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_u_count <= CNT_BITS'(QUEUE_DEPTH)) && (r_n_count <= CNT_BITS'(QUEUE_DEPTH)))
        else $error("queue occupancy above depth");

    // Only a served result carries an identifier or the urgent flag.
    a_unserved_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_o_ctl.status != ST_SERVED)) |->
        ((o_m_tdata == '0) && (r_o_ctl.from_urgent == 1'b0)))
        else $error("unserved result carries data");

    // A serve always takes the urgent queue while it holds anything.
    a_urgent_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && is_serve && !u_empty) |=> (r_u_count == $past(r_u_count) - 1'b1))
        else $error("urgent queue not served first");

    // A served result never comes from an empty queue.
    a_serve_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && is_serve && u_empty && n_empty) |=> (r_p_ctl.status == ST_EMPTY))
        else $error("serve from empty queues not flagged");

endmodule

`default_nettype wire

// ===== tb/two_class_strict_priority_queue_test.sv =====
`timescale 1ns / 1ps

module two_class_strict_priority_queue_test;
    import tcspq_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TIMEOUT_NS   = 1000000;
    localparam int REPORT_LIMIT = 10;

    // One result item as the block should produce it.
    typedef struct packed {
        t_status                status;
        logic [ID_BITS-1:0]     id;
        logic                   from_urgent;
    } t_outcome;

    // One row of the directed script; the outcome is typed in only where obvious.
    typedef struct {
        t_op                    op;
        logic [ID_BITS-1:0]     id;
        logic                   urg;
        bit                     typed;
        t_outcome               want;
    } t_script_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // [15:0] item_id
    logic [DATA_BITS-1:0]   i_s_tdata = '0;
    // [0] operation, [1] urgent
    logic [1:0]             i_s_tuser = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [15:0] served_id
    logic [DATA_BITS-1:0]   o_m_tdata;
    // [1:0] status, [2] served_urgent
    logic [2:0]             o_m_tuser;

    // Predicted queue contents, index 1 is the urgent class and 0 the normal one.
    logic [ID_BITS-1:0]     id_ring [2][QUEUE_DEPTH];
    logic [PTR_BITS-1:0]    ring_rd [2];
    logic [PTR_BITS-1:0]    ring_wr [2];
    logic [CNT_BITS-1:0]    ring_fill [2];

    t_outcome               outcomes_due[$];
    t_script_row            script[$];
    int                     mismatches = 0;
    int                     items_sent = 0;
    int                     status_seen [4];
    int                     urgent_served = 0;
    int                     hold_ticket = 0;
    int                     hold_taken = 0;
    int                     hold_left = 0;
    bit                     calm = 1'b0;

    two_class_strict_priority_queue dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [PTR_BITS-1:0] ring_next(logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Applies one request to the predicted queues and returns its result item.
    function automatic t_outcome predict_outcome(t_op op, logic [ID_BITS-1:0] id, logic urg);
        t_outcome r;
        logic     cls;
        r.status      = ST_ADDED;
        r.id          = '0;
        r.from_urgent = 1'b0;
        if (op == OP_ADD) begin
            cls = urg;
            if (ring_fill[cls] == CNT_BITS'(QUEUE_DEPTH)) begin
                r.status = ST_FULL;
            end else begin
                id_ring[cls][ring_wr[cls]] = id;
                ring_wr[cls]   = ring_next(ring_wr[cls]);
                ring_fill[cls] = ring_fill[cls] + 1'b1;
            end
        end else begin
            // Strict priority: the urgent head goes first whenever there is one.
            cls = (ring_fill[1] != 0);
            if (ring_fill[cls] == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.status       = ST_SERVED;
                r.id           = id_ring[cls][ring_rd[cls]];
                r.from_urgent  = cls;
                ring_rd[cls]   = ring_next(ring_rd[cls]);
                ring_fill[cls] = ring_fill[cls] - 1'b1;
                if (cls) urgent_served++;
            end
        end
        status_seen[r.status]++;
        return r;
    endfunction

    function automatic void add_row(t_op op, logic [ID_BITS-1:0] id, logic urg,
                                    bit typed = 1'b0, t_status st = ST_ADDED,
                                    logic [ID_BITS-1:0] sid = '0, logic surg = 1'b0);
        t_script_row r;
        r.op               = op;
        r.id               = id;
        r.urg              = urg;
        r.typed            = typed;
        r.want.status      = st;
        r.want.id          = sid;
        r.want.from_urgent = surg;
        script.push_back(r);
    endfunction

    // Identifiers lean towards the extremes and single set bits now and then.
    function automatic logic [ID_BITS-1:0] pick_id();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return ID_BITS'(1) << $urandom_range(0, ID_BITS - 1);
            default: return ID_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Offers one request item, waits for its acceptance and records what it should yield.
    task automatic offer(t_op op, logic [ID_BITS-1:0] id, logic urg,
                         bit typed = 1'b0, t_outcome typed_want = '0);
        t_outcome predicted;
        if (!calm && $urandom_range(0, 99) < 6) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= DATA_BITS'(id);
        i_s_tuser  <= {urg, op};
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        predicted = predict_outcome(op, id, urg);
        outcomes_due.push_back(typed ? typed_want : predicted);
        items_sent++;
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (hold_ticket != hold_taken) begin
            hold_taken <= hold_ticket;
            hold_left  <= HOLD_CYCLES - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(0, 99) >= 6);
        end
    end

    // Each accepted result item is compared with the oldest outstanding prediction.
    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            if (outcomes_due.size() == 0) begin
                note_mismatch($sformatf("unexpected result data=%h user=%b",
                                        o_m_tdata, o_m_tuser));
            end else begin
                want = outcomes_due.pop_front();
                if (o_m_tuser[1:0] !== want.status)
                    note_mismatch($sformatf("status expected %0d got %0d",
                                            want.status, o_m_tuser[1:0]));
                if (o_m_tdata !== DATA_BITS'(want.id))
                    note_mismatch($sformatf("served_id expected %h got %h",
                                            want.id, o_m_tdata));
                if (o_m_tuser[2] !== want.from_urgent)
                    note_mismatch($sformatf("served_urgent expected %b got %b",
                                            want.from_urgent, o_m_tuser[2]));
            end
        end
    end

    // Safety net against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Main sequence: reset, directed script, random bursts, drain and verdict.
    initial begin
        int       burst;
        int       kind;
        int       n;
        int       waited;
        logic     cls;

        for (int c = 0; c < 2; c++) begin
            ring_rd[c]   = '0;
            ring_wr[c]   = '0;
            ring_fill[c] = '0;
        end
        for (int s = 0; s < 4; s++) status_seen[s] = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Serve on an empty block, urgent before normal, FIFO order within a class,
        // extreme identifiers, and a serve whose identifier and class must be ignored.
        add_row(OP_SERVE, 16'h0000, 1'b0, 1'b1, ST_EMPTY);
        add_row(OP_ADD,   16'hFFFF, 1'b1, 1'b1, ST_ADDED);
        add_row(OP_ADD,   16'h0000, 1'b0, 1'b1, ST_ADDED);
        add_row(OP_ADD,   16'hAAAA, 1'b0, 1'b1, ST_ADDED);
        add_row(OP_ADD,   16'h5555, 1'b1, 1'b1, ST_ADDED);
        add_row(OP_SERVE, 16'h1234, 1'b0, 1'b1, ST_SERVED, 16'hFFFF, 1'b1);
        add_row(OP_SERVE, 16'h0000, 1'b1, 1'b1, ST_SERVED, 16'h5555, 1'b1);
        add_row(OP_SERVE, 16'hFFFF, 1'b1, 1'b1, ST_SERVED, 16'h0000, 1'b0);
        add_row(OP_ADD,   16'h0001, 1'b1);
        add_row(OP_SERVE, 16'h0000, 1'b0);
        add_row(OP_SERVE, 16'h0000, 1'b0);
        add_row(OP_SERVE, 16'hFFFF, 1'b1, 1'b1, ST_EMPTY);
        add_row(OP_ADD,   16'h8000, 1'b0);
        add_row(OP_ADD,   16'h7FFF, 1'b1);
        add_row(OP_ADD,   16'h00FF, 1'b0);
        add_row(OP_ADD,   16'hFF00, 1'b1);
        add_row(OP_SERVE, 16'h0000, 1'b0);
        add_row(OP_SERVE, 16'h0000, 1'b0);
        add_row(OP_SERVE, 16'h0000, 1'b0);
        add_row(OP_SERVE, 16'h0000, 1'b0);
        add_row(OP_SERVE, 16'h0000, 1'b0, 1'b1, ST_EMPTY);
        foreach (script[i]) offer(script[i].op, script[i].id, script[i].urg,
                                  script[i].typed, script[i].want);

        // Random bursts. The first two fill each class past its depth, so the full
        // status and pointer wrap are reached early; later bursts fill, drain or mix.
        burst = 0;
        while (items_sent < script.size() + RANDOM_ITEMS) begin
            if (burst == 2) hold_ticket++;
            calm = (burst >= 6 && burst < 12);
            kind = (burst < 2) ? 0 : $urandom_range(0, 9);
            case (kind)
                0, 1: begin
                    cls = (burst < 2) ? burst[0] : 1'($urandom_range(0, 1));
                    n   = QUEUE_DEPTH + $urandom_range(1, 6);
                    repeat (n) offer(OP_ADD, pick_id(), cls);
                end
                2, 3: begin
                    repeat ($urandom_range(20, 140))
                        offer(OP_SERVE, pick_id(), 1'($urandom_range(0, 1)));
                end
                default: begin
                    repeat ($urandom_range(10, 60))
                        offer(t_op'($urandom_range(0, 1)), pick_id(),
                              1'($urandom_range(0, 1)));
                end
            endcase
            burst++;
        end
        i_s_tvalid <= 1'b0;
        calm = 1'b0;

        // Let every outstanding result arrive, then let the output pipeline settle.
        waited = 0;
        while (outcomes_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (outcomes_due.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));

        $display("Requests: %0d in %0d bursts; added %0d, served %0d (%0d urgent),",
                 items_sent, burst, status_seen[ST_ADDED], status_seen[ST_SERVED],
                 urgent_served);
        $display("nothing to serve %0d, rejected as full %0d; mismatches %0d.",
                 status_seen[ST_EMPTY], status_seen[ST_FULL], mismatches);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
